// ===== rtl/imcs_pkg.sv =====
// package for the image match chi-square block
`timescale 1ns / 1ps
package imcs_pkg;
  localparam int MaxImages = 16;
  localparam int IdxW = $clog2(MaxImages);
  localparam int CntW = $clog2(MaxImages + 1);
  localparam logic [62:0] ChiMax = {63{1'b1}};
  localparam logic [15:0] PenaltyReset = 16'd1000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PRED  = 2'd1,
    OP_END   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEAR,
    ST_LINKD,
    ST_FAR,
    ST_FREE,
    ST_BUMP,
    ST_CHI,
    ST_CHI_ADD,
    ST_TOTAL,
    ST_OUT
  } state_t;

  // saturating square of a magnitude up to 2^32
  function automatic logic [62:0] sat_square(input logic [32:0] m);
    logic [65:0] p;
    p = 66'(m) * 66'(m);
    if (m >= 33'h0B504F334) sat_square = ChiMax;
    else sat_square = p[62:0];
  endfunction

  function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[63] ? ChiMax : s[62:0];
  endfunction

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    abs_diff = d[32] ? 33'(-d) : 33'(d);
  endfunction
endpackage

// ===== rtl/imcs_if.sv =====
// valid/ready channel interfaces for the image match chi-square block
`timescale 1ns / 1ps
interface imcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  modport source (output valid, op, pos_x, pos_y, input ready);
  modport sink (input valid, op, pos_x, pos_y, output ready);
endinterface

interface imcs_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] set_chi;
  logic [62:0] total_chi;
  logic [31:0] found_count;
  logic [4:0]  missing_images;
  modport source (output valid, set_chi, total_chi, found_count, missing_images,
                  input ready);
  modport sink (input valid, set_chi, total_chi, found_count, missing_images,
                output ready);
endinterface

interface imcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/image_match_chi_square.sv =====
// top level of the image match chi-square block
//
// in: op/pos_x/pos_y items. op 0 loads an observed image (up to 16 per set),
// op 1 links a predicted image, op 2 ends the set and emits one result,
// op 3 clears the running totals. cfg: penalty_weight write channel.
// out: set_chi, total_chi, found_count, missing_images on op 2 only.
// ops 0 and 3 are handled in the idle state. op 1 runs the nearest pass and,
// if the nearest slot is already linked, the farthest and free-slot passes on
// the stored distances; op 2 runs the chi pass (none with no images) and waits
// out any output stall. one shared distance unit (two squares and a saturating
// add, registered) walks the images one per cycle in the nearest and chi passes.
// in.ready is low while an item is in work, while a result waits and during
// reset; a stalled receiver holds the result steady until it is taken.
// reset (rst, synchronous) clears counts, totals, link counts and the
// penalty back to 1000; observed positions are not cleared.
`timescale 1ns / 1ps
module image_match_chi_square (
  input logic clk,
  input logic rst,
  imcs_in_if.sink in,
  imcs_out_if.source out,
  imcs_cfg_if.sink cfg
);
  import imcs_pkg::*;

  state_t state, state_next;
  logic [31:0] obs_x [MaxImages];
  logic [31:0] obs_y [MaxImages];
  logic [31:0] linked_x [MaxImages];
  logic [31:0] linked_y [MaxImages];
  logic [7:0]  link_count [MaxImages];
  logic [62:0] dsq_tab [MaxImages];
  logic [CntW-1:0] observed_count;
  logic [62:0] chi_total;
  logic [31:0] found_total;
  logic [15:0] penalty_weight;
  logic [31:0] px, py, tx, ty;
  logic [CntW-1:0] i;
  logic [IdxW-1:0] near, far, target;
  logic [62:0] bound, acc;
  logic [4:0]  missing;

  // shared distance unit
  logic [31:0] ua_x, ua_y, ub_x, ub_y;
  logic [62:0] dsq;
  logic [IdxW-1:0] ii;
  assign ii = i[IdxW-1:0];

  always_comb begin
    ua_x = obs_x[ii];
    ua_y = obs_y[ii];
    ub_x = px;
    ub_y = py;
    if (state == ST_LINKD) begin
      ua_x = obs_x[near];
      ua_y = obs_y[near];
      ub_x = linked_x[near];
      ub_y = linked_y[near];
    end else if (state == ST_CHI) begin
      ub_x = linked_x[ii];
      ub_y = linked_y[ii];
    end
  end

  logic [62:0] sq_x, sq_y;
  always_ff @(posedge clk) begin
    sq_x <= sat_square(abs_diff(ua_x, ub_x));
    sq_y <= sat_square(abs_diff(ua_y, ub_y));
  end
  assign dsq = sat_add(sq_x, sq_y);

  // penalty for one missing image
  logic [62:0] pen;
  logic [20:0] pen_prod;
  assign pen_prod = 21'(penalty_weight) * 21'(observed_count);
  assign pen = {10'd0, pen_prod, 32'd0};
  logic [62:0] pen_q;
  always_ff @(posedge clk) pen_q <= pen;

  logic i_last;
  assign i_last = (i == observed_count - CntW'(1));
  logic [IdxW-1:0] ip;  // index of the sample in sq_x/sq_y
  logic cnt_pend;       // a sample is waiting in the unit
  logic near_done;      // last nearest-search sample is in the unit
  assign near_done = cnt_pend && (ip == IdxW'(observed_count - CntW'(1)));

  assign in.ready = (state == ST_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign out.valid = (state == ST_OUT);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in.valid) begin
          unique case (op_t'(in.op))
            OP_PRED:  state_next = (observed_count == '0) ? ST_IDLE : ST_NEAR;
            OP_END:   state_next = (observed_count == '0) ? ST_TOTAL : ST_CHI;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_NEAR:    if (near_done) state_next = ST_LINKD;
      ST_LINKD: begin
        if (link_count[near] == '0) state_next = ST_IDLE;
        else if (cnt_pend) state_next = ST_FAR;
      end
      ST_FAR:     if (i_last) state_next = ST_FREE;
      ST_FREE:    if (i_last) state_next = ST_BUMP;
      ST_BUMP:    state_next = ST_IDLE;
      ST_CHI:     if (i_last) state_next = ST_CHI_ADD;
      ST_CHI_ADD: state_next = ST_TOTAL;
      ST_TOTAL:   state_next = ST_OUT;
      ST_OUT:     if (out.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      observed_count <= '0;
      chi_total <= '0;
      found_total <= '0;
      penalty_weight <= PenaltyReset;
      cnt_pend <= 1'b0;
      for (int k = 0; k < MaxImages; k++) link_count[k] <= '0;
    end else begin
      if (cfg.valid) penalty_weight <= cfg.data;
      ip <= ii;
      unique case (state)
        ST_IDLE: begin
          i <= '0;
          cnt_pend <= 1'b0;
          acc <= '0;
          missing <= '0;
          near <= '0;
          if (in.valid) begin
            px <= in.pos_x;
            py <= in.pos_y;
            unique case (op_t'(in.op))
              OP_LOAD: if (observed_count < CntW'(MaxImages)) begin
                obs_x[observed_count[IdxW-1:0]] <= in.pos_x;
                obs_y[observed_count[IdxW-1:0]] <= in.pos_y;
                link_count[observed_count[IdxW-1:0]] <= '0;
                observed_count <= observed_count + CntW'(1);
              end
              OP_PRED: if (found_total != 32'hFFFFFFFF)
                found_total <= found_total + 32'd1;
              OP_CLEAR: begin
                chi_total <= '0;
                found_total <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_NEAR: begin
          if (!i_last || !cnt_pend) i <= i + CntW'(1);
          // empty the unit before the link check
          cnt_pend <= !near_done;
          if (cnt_pend) begin
            dsq_tab[ip] <= dsq;
            if (ip == '0 || dsq < bound) begin
              bound <= dsq;
              near <= ip;
            end
          end
        end
        ST_LINKD: begin
          cnt_pend <= 1'b1;
          i <= (observed_count == CntW'(1)) ? '0 : CntW'(1);
          far <= '0;
          if (link_count[near] == '0) begin
            linked_x[near] <= px;
            linked_y[near] <= py;
            link_count[near] <= 8'd1;
          end else if (cnt_pend) begin
            if (dsq_tab[near] < dsq) begin
              tx <= linked_x[near];
              ty <= linked_y[near];
              linked_x[near] <= px;
              linked_y[near] <= py;
            end else begin
              tx <= px;
              ty <= py;
            end
          end
        end
        ST_FAR: begin
          if (i != '0 && ii != near && dsq_tab[ii] > dsq_tab[far]) far <= ii;
          if (i_last) begin
            i <= '0;
            target <= near;
          end else i <= i + CntW'(1);
          if (i_last) bound <= (i != '0 && ii != near && dsq_tab[ii] > dsq_tab[far]) ?
                               dsq_tab[ii] : dsq_tab[far];
        end
        ST_FREE: begin
          if (link_count[ii] == '0 && dsq_tab[ii] < bound) begin
            bound <= dsq_tab[ii];
            target <= ii;
            linked_x[ii] <= tx;
            linked_y[ii] <= ty;
          end
          if (!i_last) i <= i + CntW'(1);
        end
        ST_BUMP: if (link_count[target] != 8'd255)
          link_count[target] <= link_count[target] + 8'd1;
        ST_CHI: begin
          cnt_pend <= 1'b1;
          if (!i_last) i <= i + CntW'(1);
          if (cnt_pend) begin
            if (link_count[ip] != '0) acc <= sat_add(acc, dsq);
            else begin
              acc <= sat_add(acc, pen_q);
              missing <= missing + 5'd1;
            end
          end
        end
        ST_CHI_ADD: begin
          if (link_count[ip] != '0) acc <= sat_add(acc, dsq);
          else begin
            acc <= sat_add(acc, pen_q);
            missing <= missing + 5'd1;
          end
        end
        ST_TOTAL: begin
          chi_total <= sat_add(chi_total, acc);
          observed_count <= '0;
          for (int k = 0; k < MaxImages; k++) link_count[k] <= '0;
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign out.set_chi = acc;
  assign out.total_chi = chi_total;
  assign out.found_count = found_total;
  assign out.missing_images = missing;
endmodule
